### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_pkg
// Types and codes shared by the double-ended priority queue.
// ----------------------------------------------------------------------------
package dpq_pkg;

  localparam int IdW  = 31;
  localparam int KeyW = 31;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP_HI = 2'd1,
    OP_POP_LO = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [IdW-1:0]         id;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_CMP,
    S_HI_RD,
    S_HI_TOP,
    S_HI_CHK,
    S_HI_CMP,
    S_LO_RD,
    S_LO_CAP,
    S_SH_CHK,
    S_SH_WR,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    RA_POS_M1,
    RA_POS,
    RA_POS_P1
  } rd_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic    load;
    logic    load_pos_zero;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_new;
    cnt_op_t pos_op;
    cnt_op_t occ_op;
    logic    cap_top;
    logic    cap_cand;
    logic    resp;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic occ_zero;
    logic pos_zero;
    logic rd_gt;
    logic rd_eq;
    logic sh_more;
    logic out_free;
  } status_t;

endpackage

### rtl/dpq_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_in_if
// Request channel: operation code, client identifier and priority.
// ----------------------------------------------------------------------------
interface dpq_in_if
  import dpq_pkg::*;
();
  logic                   valid;
  logic                   ready;
  op_t                    op;
  logic [IdW-1:0]         client_id;
  logic signed [KeyW-1:0] priority_req;

  modport source (output valid, op, client_id, priority_req, input ready);
  modport sink (input valid, op, client_id, priority_req, output ready);
endinterface

### rtl/dpq_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_out_if
// Response channel: identifier of the removed entry and the empty flag.
// ----------------------------------------------------------------------------
interface dpq_out_if
  import dpq_pkg::*;
();
  logic           valid;
  logic           ready;
  logic [IdW-1:0] popped_id;
  logic           was_empty;

  modport source (output valid, popped_id, was_empty, input ready);
  modport sink (input valid, popped_id, was_empty, output ready);
endinterface

### rtl/dpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_ctrl
// Sequencer that walks the sorted store for inserts, pops and shifts.
// ----------------------------------------------------------------------------
module dpq_ctrl
  import dpq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  input  op_t     req_op,
  output logic    req_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RA_POS;
    cmd.pos_op = CNT_HOLD;
    cmd.occ_op = CNT_HOLD;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load          = 1'b1;
          cmd.load_pos_zero = (req_op == OP_POP_LO);
          unique case (req_op)
            OP_INSERT: state_next = st.full ? S_IDLE : S_INS_CHK;
            OP_POP_HI: state_next = st.occ_zero ? S_RESP : S_HI_RD;
            OP_POP_LO: state_next = st.occ_zero ? S_RESP : S_LO_RD;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_INS_CHK: begin
        if (st.pos_zero) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_new = 1'b1;
          cmd.occ_op = CNT_INC;
          state_next = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_POS_M1;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (st.rd_gt) begin
          cmd.pos_op = CNT_DEC;
          state_next = S_INS_CHK;
        end else begin
          cmd.wr_new = 1'b1;
          cmd.occ_op = CNT_INC;
          state_next = S_IDLE;
        end
      end
      S_HI_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_POS_M1;
        state_next = S_HI_TOP;
      end
      S_HI_TOP: begin
        cmd.cap_top  = 1'b1;
        cmd.cap_cand = 1'b1;
        cmd.pos_op   = CNT_DEC;
        state_next   = S_HI_CHK;
      end
      S_HI_CHK: begin
        if (st.pos_zero) begin
          state_next = S_SH_CHK;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_POS_M1;
          state_next = S_HI_CMP;
        end
      end
      S_HI_CMP: begin
        if (st.rd_eq) begin
          cmd.cap_cand = 1'b1;
          cmd.pos_op   = CNT_DEC;
          state_next   = S_HI_CHK;
        end else begin
          state_next = S_SH_CHK;
        end
      end
      S_LO_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_POS;
        state_next = S_LO_CAP;
      end
      S_LO_CAP: begin
        cmd.cap_cand = 1'b1;
        state_next   = S_SH_CHK;
      end
      S_SH_CHK: begin
        if (st.sh_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_POS_P1;
          state_next = S_SH_WR;
        end else begin
          cmd.occ_op = CNT_DEC;
          state_next = S_RESP;
        end
      end
      S_SH_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.pos_op = CNT_INC;
        state_next = S_SH_CHK;
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.resp   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/dpq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_datapath
// Sorted entry memory, position and occupancy counters, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dpq_datapath
  import dpq_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                st,
  input  logic [IdW-1:0]         req_id,
  input  logic signed [KeyW-1:0] req_key,
  dpq_out_if.source              rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  entry_t mem [CAPACITY];
  entry_t rdata;

  logic [CW-1:0]          occ;
  logic [CW-1:0]          pos;
  logic signed [KeyW-1:0] new_key;
  logic [IdW-1:0]         new_id;
  logic signed [KeyW-1:0] top_key;
  logic [IdW-1:0]         cand_id;
  logic                   empty_flag;
  logic                   out_valid;
  logic [IdW-1:0]         out_id;
  logic                   out_empty;

  logic [CW-1:0] pos_m1;
  logic [CW-1:0] pos_p1;
  logic [AW-1:0] rd_addr;
  entry_t        wdata;

  assign pos_m1 = pos - CW'(1);
  assign pos_p1 = pos + CW'(1);

  always_comb begin
    unique case (cmd.rd_sel)
      RA_POS_M1: rd_addr = pos_m1[AW-1:0];
      RA_POS_P1: rd_addr = pos_p1[AW-1:0];
      default:   rd_addr = pos[AW-1:0];
    endcase
  end

  always_comb begin
    wdata = rdata;
    if (cmd.wr_new) begin
      wdata.key = new_key;
      wdata.id  = new_id;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (cmd.wr_en) begin
      mem[pos[AW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      unique case (cmd.occ_op)
        CNT_INC: occ <= occ + CW'(1);
        CNT_DEC: occ <= occ - CW'(1);
        default: occ <= occ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos        <= cmd.load_pos_zero ? '0 : occ;
      new_key    <= req_key;
      new_id     <= req_id;
      empty_flag <= (occ == '0);
    end else begin
      unique case (cmd.pos_op)
        CNT_INC: pos <= pos_p1;
        CNT_DEC: pos <= pos_m1;
        default: pos <= pos;
      endcase
    end
    if (cmd.cap_top) begin
      top_key <= rdata.key;
    end
    if (cmd.cap_cand) begin
      cand_id <= rdata.id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.resp) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_id    <= empty_flag ? '0 : cand_id;
      out_empty <= empty_flag;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.popped_id = out_id;
  assign rsp.was_empty = out_empty;

  assign st.full     = (occ == CW'(CAPACITY));
  assign st.occ_zero = (occ == '0);
  assign st.pos_zero = (pos == '0);
  assign st.rd_gt    = ($signed(rdata.key) > $signed(new_key));
  assign st.rd_eq    = (rdata.key == top_key);
  assign st.sh_more  = ({1'b0, pos} + (CW + 1)'(1)) < {1'b0, occ};
  assign st.out_free = !out_valid || rsp.ready;

  `ASSERT_SAME(a_occ_bound, 1'b1, occ <= CW'(CAPACITY), "occupancy above capacity")
  `ASSERT_SAME(a_wr_in_range, cmd.wr_en, pos <= occ && pos < CW'(CAPACITY),
    "write beyond filled region")
  `ASSERT_SAME(a_no_grow_full, cmd.occ_op == CNT_INC, occ < CW'(CAPACITY),
    "insert committed into a full store")
  `ASSERT_NEXT(a_resp_shows, cmd.resp, out_valid, "result beat not presented")

endmodule

### rtl/double_ended_priority_queue.sv
`timescale 1ns / 1ps
// Insert: walks down from the top, moving each entry with a larger key up one place.
// Pop lowest: shifts the entries above the bottom down one place through the memory.
// Pop highest: walks past the older entries sharing the top priority, then shifts down
// those above the oldest. Empty pops answer with was_empty set; ignored codes and dropped
// inserts get no response. One item at a time; a held result beat stalls the next pop.
// Synchronous reset empties the queue; the memory needs no clearing pass.
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Sorted store of identifier and priority pairs, popped at either end.
// ----------------------------------------------------------------------------
module double_ended_priority_queue
  import dpq_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input logic       clk,
  input logic       rst,
  dpq_in_if.sink    req,
  dpq_out_if.source rsp
);

  cmd_t    cmd;
  status_t st;

  dpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  dpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .st      (st),
    .req_id  (req.client_id),
    .req_key (req.priority_req),
    .rsp     (rsp)
  );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives inserts and pops at either end into the double-ended priority queue
// and checks every response beat against a sorted-array model of the store.
// The run covers empty and full stores, ties, and extreme priorities.
// ----------------------------------------------------------------------------
module testbench;
  import dpq_pkg::*;

  localparam int Depth = 1024;
  localparam int QuietMax = 20000;

  typedef struct {
    op_t                    op;
    logic [IdW-1:0]         id;
    logic signed [KeyW-1:0] key;
    bit                     drain;
    int                     phase;
  } request_t;

  typedef struct {
    logic [IdW-1:0] id;
    logic           empty;
  } response_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dpq_in_if req_if ();
  dpq_out_if rsp_if ();

  double_ended_priority_queue #(.CAPACITY(Depth)) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  request_t  pending_reqs[$];
  response_t expected_pops[$];

  logic signed [KeyW-1:0] model_keys[Depth];
  logic [IdW-1:0]         model_ids[Depth];
  int                     model_count = 0;

  int  cur_phase = 0;
  int  mismatches = 0;
  int  idle_after_drain = 0;
  int  stall_cycles = 0;

  function automatic int send_idle_pct(int ph);
    return (ph == 0) ? 22 : (ph == 1) ? 72 : 0;
  endfunction

  function automatic int recv_idle_pct(int ph);
    return (ph == 0) ? 72 : (ph == 1) ? 22 : 0;
  endfunction

  // Applies one accepted request to the model store; a pop queues its response.
  function automatic void predict_queue_op(op_t op, logic [IdW-1:0] id,
                                           logic signed [KeyW-1:0] key);
    int pos;
    response_t r;
    if (op == OP_INSERT) begin
      if (model_count < Depth) begin
        pos = model_count;
        while (pos > 0 && model_keys[pos-1] > key) pos--;
        for (int i = model_count; i > pos; i--) begin
          model_keys[i] = model_keys[i-1];
          model_ids[i]  = model_ids[i-1];
        end
        model_keys[pos] = key;
        model_ids[pos]  = id;
        model_count++;
      end
    end else if (op == OP_POP_HI || op == OP_POP_LO) begin
      if (model_count == 0) begin
        r.id = '0;
        r.empty = 1'b1;
      end else begin
        if (op == OP_POP_HI) begin
          pos = model_count - 1;
          while (pos > 0 && model_keys[pos-1] == model_keys[model_count-1]) pos--;
        end else begin
          pos = 0;
        end
        r.id = model_ids[pos];
        r.empty = 1'b0;
        for (int i = pos; i + 1 < model_count; i++) begin
          model_keys[i] = model_keys[i+1];
          model_ids[i]  = model_ids[i+1];
        end
        model_count--;
      end
      expected_pops.push_back(r);
    end
  endfunction

  task automatic add_req(op_t op, logic [IdW-1:0] id, logic signed [KeyW-1:0] key,
                         int ph, bit drain = 1'b0);
    request_t t;
    t.op = op;
    t.id = id;
    t.key = key;
    t.phase = ph;
    t.drain = drain;
    pending_reqs.push_back(t);
  endtask

  task automatic add_random_req(int ph);
    int sel;
    op_t op;
    logic signed [KeyW-1:0] key;
    sel = $urandom_range(0, 99);
    if (sel < 46) op = OP_INSERT;
    else if (sel < 71) op = OP_POP_HI;
    else if (sel < 96) op = OP_POP_LO;
    else op = OP_NONE;
    if ($urandom_range(0, 1)) key = KeyW'($signed($urandom_range(0, 8)) - 4);
    else key = KeyW'($urandom);
    add_req(op, IdW'($urandom), key, ph, $urandom_range(0, 99) == 0);
  endtask

  // Driver: a new beat is offered only once the previous one has been taken.
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      req_if.op <= OP_NONE;
      req_if.client_id <= '0;
      req_if.priority_req <= '0;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct(cur_phase));
      if (!req_if.valid || req_if.ready) begin
        if (pending_reqs.size() != 0 &&
            !(pending_reqs[0].drain &&
              (expected_pops.size() != 0 || idle_after_drain < 60)) &&
            $urandom_range(0, 99) >= send_idle_pct(pending_reqs[0].phase)) begin
          request_t t;
          t = pending_reqs.pop_front();
          cur_phase <= t.phase;
          req_if.valid <= 1'b1;
          req_if.op <= t.op;
          req_if.client_id <= t.id;
          req_if.priority_req <= t.key;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts on accepted requests, checks accepted responses.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_pops.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected response beat: id=%0h empty=%0b",
                     rsp_if.popped_id, rsp_if.was_empty);
          mismatches++;
        end else begin
          response_t r;
          r = expected_pops.pop_front();
          if (r.id !== rsp_if.popped_id || r.empty !== rsp_if.was_empty) begin
            if (mismatches < 10)
              $display("response beat: expected id=%0h empty=%0b, got id=%0h empty=%0b",
                       r.id, r.empty, rsp_if.popped_id, rsp_if.was_empty);
            mismatches++;
          end
        end
      end
      if (req_if.valid && req_if.ready)
        predict_queue_op(req_if.op, req_if.client_id, req_if.priority_req);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      idle_after_drain <= (expected_pops.size() == 0) ? idle_after_drain + 1 : 0;
      if (stall_cycles >= QuietMax) begin
        $display("double_ended_priority_queue: mismatch");
        $finish;
      end
    end
  end

  initial begin
    // Directed: empty pops, unused code, extreme keys and ids, ties.
    add_req(OP_POP_HI, IdW'(5), '0, 0);
    add_req(OP_POP_LO, IdW'(6), '0, 0);
    add_req(OP_NONE, IdW'(7), '0, 0);
    add_req(OP_INSERT, IdW'(1), KeyW'(32'h3fffffff), 0);
    add_req(OP_INSERT, IdW'(2), KeyW'(-32'sh3fffffff), 0);
    add_req(OP_INSERT, '1, KeyW'(32'h40000000), 0);
    add_req(OP_INSERT, '0, '0, 0);
    add_req(OP_INSERT, IdW'(11), KeyW'(7), 0);
    add_req(OP_INSERT, IdW'(12), KeyW'(7), 0);
    add_req(OP_INSERT, IdW'(13), KeyW'(7), 0);
    add_req(OP_INSERT, IdW'(14), KeyW'(32'h3fffffff), 0);
    add_req(OP_NONE, '1, '1, 0);
    add_req(OP_POP_HI, '0, '0, 0);
    add_req(OP_POP_HI, '0, '0, 0);
    add_req(OP_POP_LO, '0, '0, 0);
    add_req(OP_POP_LO, '0, '0, 0);
    add_req(OP_POP_HI, '0, '0, 0);
    add_req(OP_POP_LO, '0, '0, 0);
    add_req(OP_POP_LO, '0, '0, 0);
    add_req(OP_POP_HI, '0, '0, 0);
    add_req(OP_POP_LO, '0, '0, 0, 1'b1);
    for (int i = 0; i < 100; i++) add_random_req(i * 3 / 100);
    // Fill to capacity with the largest key so each insert moves nothing.
    add_req(OP_INSERT, IdW'(100), KeyW'(32'h3fffffff), 2, 1'b1);
    for (int i = 1; i < Depth + 3; i++)
      add_req(OP_INSERT, IdW'($urandom), KeyW'(32'h3fffffff), 2);
    add_req(OP_POP_HI, '0, '0, 2);
    add_req(OP_INSERT, IdW'(200), KeyW'(32'h3fffffff), 2);
    add_req(OP_INSERT, IdW'(201), KeyW'(32'h3fffffff), 2);
    add_req(OP_POP_LO, '0, '0, 2);
    add_req(OP_POP_HI, '0, '0, 2);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || req_if.valid || expected_pops.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_pops.size() == 0) begin
      $display("double_ended_priority_queue: match");
    end else begin
      $display("double_ended_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/dpq_pkg.sv
rtl/dpq_in_if.sv
rtl/dpq_out_if.sv
rtl/dpq_ctrl.sv
rtl/dpq_datapath.sv
rtl/double_ended_priority_queue.sv
sim/testbench.sv
